### design/sfl_pkg.sv
// sfl_pkg: shared types and constants for the slot allocator free list
// used by the controller, the datapath and the top level
`default_nettype none

package sfl_pkg;

    localparam int SLOTS   = 256;
    localparam int SLOT_W  = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CHECK = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture request, start link read at the head
        logic exec;     // apply request and fill the result register
    } t_sfl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_blocked;  // result register full and not taken this cycle
    } t_sfl_stat;

endpackage

`default_nettype wire

### design/sfl_ram.sv
// sfl_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module sfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### design/sfl_ctrl.sv
// sfl_ctrl: two state controller sequencing request capture and execution
// depends on sfl_pkg
`default_nettype none

module sfl_ctrl
    import sfl_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_sfl_stat i_stat,
    output logic           o_stall,
    output t_sfl_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_stat.out_blocked) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall    = 1'b1;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = i_valid;
            end
            S_EXEC: begin
                o_cmd.exec = !i_stat.out_blocked;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

### design/sfl_dp.sv
// sfl_dp: free list datapath: head, high-water mark, live count, freed marks,
// link ram and result register; depends on sfl_pkg and sfl_ram
`default_nettype none

module sfl_dp
    import sfl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_sfl_cmd          i_cmd,
    output t_sfl_stat              o_stat,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [SLOT_W-1:0] i_slot_id,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [SLOT_W-1:0]      o_granted_slot,
    output logic [1:0]             o_status,
    output logic [COUNT_W-1:0]     o_live_count
);

    logic [1:0]         r_req;
    logic [SLOT_W-1:0]  r_slot;
    logic [COUNT_W-1:0] r_hw,   n_hw;
    logic [COUNT_W-1:0] r_head, n_head;
    logic [COUNT_W-1:0] r_live, n_live;
    logic [SLOTS-1:0]   r_freed, n_freed;
    logic               r_ovalid;
    logic [SLOT_W-1:0]  r_ogrant, n_ogrant;
    t_status            r_ostatus, n_ostatus;
    logic [COUNT_W-1:0] r_olive;

    logic [SLOT_W-1:0]  link_rd;
    logic               link_wr_en;
    logic               slot_live;

    sfl_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (r_head[SLOT_W-1:0]),
        .i_rd_en   (i_cmd.load),
        .i_rd_addr (r_head[SLOT_W-1:0]),
        .o_rd_data (link_rd)
    );

    assign slot_live = ({1'b0, r_slot} < r_hw) && !r_freed[r_slot];

    always_comb begin
        n_hw       = r_hw;
        n_head     = r_head;
        n_live     = r_live;
        n_freed    = r_freed;
        n_ogrant   = '0;
        n_ostatus  = ST_BAD;
        link_wr_en = 1'b0;
        case (r_req)
            REQ_ALLOC: begin
                if (r_live >= COUNT_W'(SLOTS)) begin
                    n_ostatus = ST_FULL;
                end else if (r_head < COUNT_W'(SLOTS)) begin
                    // fresh slot at the mark, otherwise pop the stored link
                    if (r_head == r_hw) begin
                        n_hw   = r_hw + 1'b1;
                        n_head = r_head + 1'b1;
                    end else begin
                        n_head = {1'b0, link_rd};
                    end
                    n_freed[r_head[SLOT_W-1:0]] = 1'b0;
                    n_live    = r_live + 1'b1;
                    n_ogrant  = r_head[SLOT_W-1:0];
                    n_ostatus = ST_OK;
                end
            end
            REQ_FREE: begin
                // stub slot never freed
                if (r_slot != '0 && slot_live) begin
                    link_wr_en      = i_cmd.exec;
                    n_head          = {1'b0, r_slot};
                    n_freed[r_slot] = 1'b1;
                    n_live          = r_live - 1'b1;
                    n_ostatus       = ST_OK;
                end
            end
            REQ_CHECK: begin
                n_ostatus = slot_live ? ST_OK : ST_BAD;
            end
            default: n_ostatus = ST_BAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hw     <= COUNT_W'(1);
            r_head   <= COUNT_W'(1);
            r_live   <= COUNT_W'(1);
            r_freed  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_hw     <= n_hw;
                r_head   <= n_head;
                r_live   <= n_live;
                r_freed  <= n_freed;
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_req_type;
            r_slot <= i_slot_id;
        end
        if (i_cmd.exec) begin
            r_ogrant  <= n_ogrant;
            r_ostatus <= n_ostatus;
            r_olive   <= n_live;
        end
    end

    assign o_stat.out_blocked = r_ovalid && i_stall;

    assign o_valid        = r_ovalid;
    assign o_granted_slot = r_ogrant;
    assign o_status       = r_ostatus;
    assign o_live_count   = r_olive;

endmodule

`default_nettype wire

### design/slot_allocator_free_list.sv
// slot_allocator_free_list: top level joining controller and datapath
// depends on sfl_pkg, sfl_ctrl, sfl_dp
//
//   channel   direction  handshake           fields
//   request   in         i_valid / o_stall   i_req_type, i_slot_id
//   result    out        o_valid / i_stall   o_granted_slot, o_status, o_live_count
//
// each request is handled as a capture with the link ram read at the head,
// then the update using the registered read data
// one request is in flight at a time; the next is taken once the previous is applied
// reset is synchronous; all slots start free with only the stub live, no clearing pass
// a result waiting in the output register does not block capture of the next request,
// only its execution
`default_nettype none

module slot_allocator_free_list
    import sfl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [SLOT_W-1:0]  i_slot_id,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [SLOT_W-1:0]       o_granted_slot,
    output logic [1:0]              o_status,
    output logic [COUNT_W-1:0]      o_live_count
);

    t_sfl_cmd  cmd;
    t_sfl_stat stat;

    sfl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    sfl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_req_type     (i_req_type),
        .i_slot_id      (i_slot_id),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_granted_slot (o_granted_slot),
        .o_status       (o_status),
        .o_live_count   (o_live_count)
    );

`ifndef SYNTHESIS
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("request taken while previous still executing");

    a_grant_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_granted_slot != '0) |-> (o_status == ST_OK))
        else $error("slot granted with non-ok status");

    a_live_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_live_count != '0))
        else $error("live count lost the stub slot");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.exec |=> o_valid)
        else $error("executed request produced no result");
`endif

endmodule

`default_nettype wire
